### rtl/periodic_task_ready_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Periodic task ready scheduler: assertion macros
// Shared check macros, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_READY_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_READY_SCHEDULER_DEFINES_SVH

// Property must hold at every rising edge outside reset.
`define PTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PTRS_ASSERT_NEVER(lbl, expr, msg) \
  `PTRS_ASSERT(lbl, !(expr), msg)

`endif

### rtl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler package
// Widths, command and status codes, FSM states and control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrs_pkg;

  localparam int TaskSlotsDefault = 8;
  localparam int PeriodW          = 16;
  localparam int IdW              = 6;
  localparam int IdOutW           = 3;
  localparam int CmdW             = 2;
  localparam int StatusW          = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE,
    CMD_TICK,
    CMD_DISPATCH,
    CMD_RESERVED
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_USED,
    ST_BAD_ID,
    ST_NONE
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_TICK,
    S_DISP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic create;
    logic tick;
    logic disp;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic tick_last;
    logic disp_done;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

### rtl/ptrs_if.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptrs_req_if;
  logic                         valid;
  logic                         ready;
  logic [ptrs_pkg::CmdW-1:0]    cmd;
  logic [ptrs_pkg::IdW-1:0]     task_id;
  logic [ptrs_pkg::PeriodW-1:0] period;
  logic                         handle_present;

  modport source (output valid, cmd, task_id, period, handle_present, input ready);
  modport sink   (input valid, cmd, task_id, period, handle_present, output ready);
endinterface

interface ptrs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ptrs_pkg::StatusW-1:0] status;
  logic [ptrs_pkg::IdOutW-1:0]  task_id_out;

  modport source (output valid, status, task_id_out, input ready);
  modport sink   (input valid, status, task_id_out, output ready);
endinterface

`default_nettype wire

### rtl/ptrs_ram.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler RAM
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_ram #(
  parameter int WIDTH = 2 * ptrs_pkg::PeriodW,
  parameter int DEPTH = ptrs_pkg::TaskSlotsDefault,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/ptrs_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler controller
// Sequences create, tick sweep, dispatch scan and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [ptrs_pkg::CmdW-1:0] req_cmd_i,
  output logic                      req_ready_o,
  input  ptrs_pkg::stat_t           stat_i,
  output ptrs_pkg::ctrl_t           ctrl_o
);

  ptrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptrs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ptrs_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.accept = 1'b1;
          case (ptrs_pkg::cmd_e'(req_cmd_i))
            ptrs_pkg::CMD_CREATE:   state_d = ptrs_pkg::S_CREATE;
            ptrs_pkg::CMD_TICK:     state_d = ptrs_pkg::S_TICK;
            ptrs_pkg::CMD_DISPATCH: state_d = ptrs_pkg::S_DISP;
            default:                state_d = ptrs_pkg::S_EMIT;
          endcase
        end
      end
      ptrs_pkg::S_CREATE: begin
        ctrl_o.create = 1'b1;
        state_d       = ptrs_pkg::S_EMIT;
      end
      ptrs_pkg::S_TICK: begin
        ctrl_o.tick = 1'b1;
        if (stat_i.tick_last) begin
          state_d = ptrs_pkg::S_EMIT;
        end
      end
      ptrs_pkg::S_DISP: begin
        ctrl_o.disp = 1'b1;
        if (stat_i.disp_done) begin
          state_d = ptrs_pkg::S_EMIT;
        end
      end
      ptrs_pkg::S_EMIT: begin
        // wait for the output register to drain
        if (!stat_i.out_busy) begin
          ctrl_o.emit = 1'b1;
          state_d     = ptrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ptrs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ptrs_datapath.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler datapath
// Slot flags, period/count RAM, tick pipeline, dispatch scan, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrs_datapath #(
  parameter int TASK_SLOTS = ptrs_pkg::TaskSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptrs_pkg::ctrl_t              ctrl_i,
  output ptrs_pkg::stat_t              stat_o,
  input  logic [ptrs_pkg::IdW-1:0]     task_id_i,
  input  logic [ptrs_pkg::PeriodW-1:0] period_i,
  input  logic                         handle_present_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic [ptrs_pkg::StatusW-1:0] rsp_status_o,
  output logic [ptrs_pkg::IdOutW-1:0]  rsp_task_id_o
);

  localparam int PerW  = ptrs_pkg::PeriodW;
  localparam int IdW   = ptrs_pkg::IdW;
  localparam int OutW  = ptrs_pkg::IdOutW;
  localparam int SlotW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CntW  = $clog2(TASK_SLOTS + 1);
  localparam int RamW  = 2 * PerW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TASK_SLOTS - 1);
  localparam logic [CntW-1:0]  SlotCnt  = CntW'(TASK_SLOTS);
  localparam logic [CntW-1:0]  LastCnt  = CntW'(TASK_SLOTS - 1);
  localparam logic [IdW:0]     IdLimit  = (IdW + 1)'(TASK_SLOTS);

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  // control state
  logic [TASK_SLOTS-1:0] in_use_q, in_use_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;
  logic [SlotW-1:0]      scan_q, scan_d;
  logic [CntW-1:0]       tick_rd_q, tick_rd_d;
  logic                  wb_valid_q, wb_valid_d;
  logic [SlotW-1:0]      disp_s_q, disp_s_d;
  logic [CntW-1:0]       disp_k_q, disp_k_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  logic [IdW-1:0]          id_q;
  logic [PerW-1:0]         per_q;
  logic                    hp_q;
  logic [SlotW-1:0]        wb_slot_q, wb_slot_d;
  ptrs_pkg::status_e       res_status_q, res_status_d;
  logic [OutW-1:0]         res_id_q, res_id_d;
  ptrs_pkg::status_e       out_status_q, out_status_d;
  logic [OutW-1:0]         out_id_q, out_id_d;

  // RAM holds {period, count} per slot
  logic                    ram_we;
  logic [SlotW-1:0]        ram_waddr;
  logic [RamW-1:0]         ram_wdata;
  logic [RamW-1:0]         ram_rdata;

  logic [SlotW-1:0]        id_slot;
  logic                    id_ok;
  logic                    tick_issue;
  logic [PerW-1:0]         wb_period;
  logic [PerW-1:0]         cnt_inc;
  logic                    disp_hit;
  logic                    disp_last;
  logic [SlotW+OutW-1:0]   disp_ext;

  ptrs_ram #(
    .WIDTH (RamW),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (tick_rd_q[SlotW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign id_slot    = id_q[SlotW-1:0];
  assign id_ok      = {1'b0, id_q} < IdLimit;
  assign tick_issue = tick_rd_q != SlotCnt;
  assign wb_period  = ram_rdata[RamW-1:PerW];
  assign cnt_inc    = ram_rdata[PerW-1:0] + 1'b1;
  assign disp_hit   = ready_q[disp_s_q];
  assign disp_last  = disp_k_q == LastCnt;
  assign disp_ext   = {{OutW{1'b0}}, disp_s_q};

  always_comb begin
    in_use_d     = in_use_q;
    ready_d      = ready_q;
    scan_d       = scan_q;
    tick_rd_d    = tick_rd_q;
    disp_s_d     = disp_s_q;
    disp_k_d     = disp_k_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    ram_we       = 1'b0;
    ram_waddr    = wb_slot_q;
    ram_wdata    = {wb_period, cnt_inc};

    if (ctrl_i.accept) begin
      res_status_d = ptrs_pkg::ST_OK;
      res_id_d     = '0;
      tick_rd_d    = '0;
      disp_s_d     = scan_q;
      disp_k_d     = '0;
    end

    if (ctrl_i.create) begin
      if (!id_ok) begin
        res_status_d = ptrs_pkg::ST_BAD_ID;
      end else if (in_use_q[id_slot]) begin
        res_status_d = ptrs_pkg::ST_USED;
      end else begin
        in_use_d[id_slot] = hp_q;
        ready_d[id_slot]  = 1'b0;
        ram_we            = 1'b1;
        ram_waddr         = id_slot;
        ram_wdata         = {per_q, {PerW{1'b0}}};
      end
    end

    // tick: read slot n while writing back slot n-1
    wb_valid_d = ctrl_i.tick && tick_issue;
    wb_slot_d  = tick_rd_q[SlotW-1:0];
    if (ctrl_i.tick && tick_issue) begin
      tick_rd_d = tick_rd_q + 1'b1;
    end
    if (wb_valid_q && in_use_q[wb_slot_q]) begin
      ram_we = 1'b1;
      if (cnt_inc >= wb_period) begin
        ram_wdata          = {wb_period, {PerW{1'b0}}};
        ready_d[wb_slot_q] = 1'b1;
      end
    end

    if (ctrl_i.disp) begin
      if (disp_hit) begin
        ready_d[disp_s_q] = 1'b0;
        scan_d            = next_slot(disp_s_q);
        res_id_d          = disp_ext[OutW-1:0];
      end else if (disp_last) begin
        res_status_d = ptrs_pkg::ST_NONE;
      end else begin
        disp_s_d = next_slot(disp_s_q);
        disp_k_d = disp_k_q + 1'b1;
      end
    end

    if (ctrl_i.emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_id_d     = res_id_q;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      ready_q     <= '0;
      scan_q      <= '0;
      tick_rd_q   <= '0;
      wb_valid_q  <= 1'b0;
      disp_s_q    <= '0;
      disp_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_use_q    <= in_use_d;
      ready_q     <= ready_d;
      scan_q      <= scan_d;
      tick_rd_q   <= tick_rd_d;
      wb_valid_q  <= wb_valid_d;
      disp_s_q    <= disp_s_d;
      disp_k_q    <= disp_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      id_q  <= task_id_i;
      per_q <= period_i;
      hp_q  <= handle_present_i;
    end
    wb_slot_q    <= wb_slot_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
  end

  assign stat_o.tick_last = wb_valid_q && !tick_issue;
  assign stat_o.disp_done = ctrl_i.disp && (disp_hit || disp_last);
  assign stat_o.out_busy  = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o   = out_valid_q;
  assign rsp_status_o  = out_status_q;
  assign rsp_task_id_o = out_id_q;

endmodule

`default_nettype wire

### rtl/periodic_task_ready_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler
// Time-triggered cooperative scheduler core: slot table, tick and dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command item (create, tick, dispatch) with valid/ready;
//   rsp_o returns exactly one item per command: status and the slot that
//   dispatch picked. One command is processed at a time; req_i.ready is high
//   only while the block is idle.
//   Per command: create checks the id and writes its slot; tick sweeps the
//   slots one per cycle through the period/count RAM with a registered
//   read/write-back pipeline; dispatch scans one ready flag per cycle from
//   the scan pointer; an unused command goes straight to the response.
//   The response sits in an output register; a stalled receiver holds it and
//   the block waits before it presents the next response, but a new command
//   is accepted while a response is still waiting.
//   Reset clears all slot flags, the scan pointer and the response valid; no
//   clearing pass is needed, RAM data is only used for slots that were created.
`default_nettype none

`include "periodic_task_ready_scheduler_defines.svh"

module periodic_task_ready_scheduler #(
  parameter int TASK_SLOTS = ptrs_pkg::TaskSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptrs_req_if.sink   req_i,
  ptrs_rsp_if.source rsp_o
);

  ptrs_pkg::ctrl_t ctrl;
  ptrs_pkg::stat_t stat;

  ptrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.cmd),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ptrs_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .task_id_i        (req_i.task_id),
    .period_i         (req_i.period),
    .handle_present_i (req_i.handle_present),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_status_o     (rsp_o.status),
    .rsp_task_id_o    (rsp_o.task_id_out)
  );

  `PTRS_ASSERT(a_ctrl_onehot,
    $onehot0({ctrl.accept, ctrl.create, ctrl.tick, ctrl.disp, ctrl.emit}),
    "more than one controller command active")
  `PTRS_ASSERT(a_emit_valid, ctrl.emit |=> rsp_o.valid,
    "response not presented after emit")
  `PTRS_ASSERT_NEVER(a_tick_last_stray, stat.tick_last && !ctrl.tick,
    "tick write-back outside the tick sweep")
  `PTRS_ASSERT_NEVER(a_accept_busy, req_i.valid && req_i.ready && !ctrl.accept,
    "item accepted while the controller is busy")

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Periodic task ready scheduler testbench
// Drives create, tick and dispatch commands through the request channel and
// checks every response against an in-order prediction of the slot table,
// under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import ptrs_pkg::*;

  localparam int SLOTS          = TaskSlotsDefault;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 3 * SLOTS;

  typedef struct packed {
    status_e             status;
    logic [IdOutW-1:0]   slot;
  } sched_rsp_t;

  logic clk;
  logic rst_n;

  ptrs_req_if req_ch ();
  ptrs_rsp_if rsp_ch ();

  periodic_task_ready_scheduler #(
    .TASK_SLOTS(SLOTS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // Shadow copy of the slot table
  logic                 tbl_used   [SLOTS];
  logic                 tbl_ready  [SLOTS];
  logic [PeriodW-1:0]   tbl_period [SLOTS];
  logic [PeriodW-1:0]   tbl_count  [SLOTS];
  int                   tbl_scan;

  sched_rsp_t sched_resp_q[$];

  int errors;
  int stall_cycles;
  int n_create, n_tick, n_dispatch, n_picked, n_refused;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_wait_left;
  int rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Works out the response of one accepted command and updates the table.
  function automatic void sched_predict(cmd_e c, logic [IdW-1:0] id,
                                        logic [PeriodW-1:0] per, logic hp);
    sched_rsp_t         r;
    logic [PeriodW-1:0] nxt;
    int                 s;
    bit                 found;
    r.status = ST_OK;
    r.slot   = '0;
    found    = 1'b0;
    case (c)
      CMD_CREATE: begin
        n_create++;
        if (int'(id) >= SLOTS) begin
          r.status = ST_BAD_ID;
        end else if (tbl_used[id]) begin
          r.status = ST_USED;
        end else begin
          // without a handle the slot is written but stays free
          tbl_used[id]   = hp;
          tbl_ready[id]  = 1'b0;
          tbl_period[id] = per;
          tbl_count[id]  = '0;
        end
        if (r.status != ST_OK) n_refused++;
      end
      CMD_TICK: begin
        n_tick++;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[i]) begin
            nxt = tbl_count[i] + 1'b1;
            if (nxt >= tbl_period[i]) begin
              nxt          = '0;
              tbl_ready[i] = 1'b1;
            end
            tbl_count[i] = nxt;
          end
        end
      end
      CMD_DISPATCH: begin
        n_dispatch++;
        for (int k = 0; k < SLOTS; k++) begin
          s = (tbl_scan + k) % SLOTS;
          if (!found && tbl_ready[s]) begin
            found        = 1'b1;
            tbl_ready[s] = 1'b0;
            tbl_scan     = (s + 1) % SLOTS;
            r.slot       = s[IdOutW-1:0];
          end
        end
        if (found) n_picked++;
        else r.status = ST_NONE;
      end
      default: ;
    endcase
    sched_resp_q.push_back(r);
  endfunction

  // Offers one command item and returns once it has been accepted.
  task automatic send_cmd(cmd_e c, logic [IdW-1:0] id, logic [PeriodW-1:0] per,
                          logic hp);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid          <= 1'b1;
    req_ch.cmd            <= c;
    req_ch.task_id        <= id;
    req_ch.period         <= per;
    req_ch.handle_present <= hp;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sched_predict(c, id, per, hp);
  endtask

  task automatic send_random_cmd();
    int                 sel;
    cmd_e               c;
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] per;
    sel = $urandom_range(0, 99);
    if (sel < 25)      c = CMD_CREATE;
    else if (sel < 60) c = CMD_TICK;
    else if (sel < 95) c = CMD_DISPATCH;
    else               c = CMD_RESERVED;
    if ($urandom_range(0, 9) < 7) begin
      id = IdW'($urandom_range(0, SLOTS - 1));
    end else begin
      id = IdW'($urandom_range(SLOTS, 63));
    end
    sel = $urandom_range(0, 99);
    if (sel < 60)      per = PeriodW'($urandom_range(0, 3));
    else if (sel < 85) per = PeriodW'($urandom_range(4, 20));
    else               per = PeriodW'($urandom());
    send_cmd(c, id, per, ($urandom_range(0, 3) != 0));
  endtask

  // Bad ids, taken slot, create without a handle, empty dispatch, unused
  // command, round-robin wrap and the period extremes.
  task automatic test_directed();
    send_cmd(CMD_CREATE,   6'd8,  16'd3,      1'b1);
    send_cmd(CMD_CREATE,   6'd63, 16'hFFFF,   1'b1);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_CREATE,   6'd0,  16'd0,      1'b1);
    send_cmd(CMD_CREATE,   6'd0,  16'd3,      1'b1);
    send_cmd(CMD_CREATE,   6'd3,  16'd5,      1'b0);
    send_cmd(CMD_CREATE,   6'd3,  16'd2,      1'b1);
    send_cmd(CMD_CREATE,   6'd7,  16'd1,      1'b1);
    send_cmd(CMD_CREATE,   6'd5,  16'hFFFF,   1'b1);
    send_cmd(CMD_RESERVED, 6'd42, 16'hA5A5,   1'b1);
    send_cmd(CMD_TICK,     6'd63, 16'hFFFF,   1'b1);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd63, 16'hFFFF,   1'b1);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_TICK,     6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_TICK,     6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
    send_cmd(CMD_DISPATCH, 6'd0,  16'd0,      1'b0);
  endtask

  task automatic test_random_mix(int n, bit tx_idle, bit rx_idle);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    repeat (n) send_random_cmd();
  endtask

  // Receiver holds off long enough that the output register fills and the
  // request side has to stall.
  task automatic test_output_stall();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_hold_left = 120;
    repeat (30) send_random_cmd();
  endtask

  // Receiver: random per-item wait plus the optional long hold.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_wait_left > 0) begin
        rsp_ch.ready <= 1'b0;
        rx_wait_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Response check, oldest expectation first.
  always @(posedge clk) begin
    sched_rsp_t want;
    if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      rx_wait_left = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (sched_resp_q.size() == 0) begin
        $error("response with nothing expected: status %0d task_id_out %0d",
               rsp_ch.status, rsp_ch.task_id_out);
        errors++;
      end else begin
        want = sched_resp_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.task_id_out !== want.slot) begin
          $error("task_id_out: expected %0d, got %0d", want.slot, rsp_ch.task_id_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", stall_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    int tail;
    errors       = 0;
    stall_cycles = 0;
    n_create     = 0;
    n_tick       = 0;
    n_dispatch   = 0;
    n_picked     = 0;
    n_refused    = 0;
    rx_wait_left = 0;
    rx_hold_left = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    tbl_scan     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]   = 1'b0;
      tbl_ready[i]  = 1'b0;
      tbl_period[i] = '0;
      tbl_count[i]  = '0;
    end
    req_ch.valid          = 1'b0;
    req_ch.cmd            = CMD_CREATE;
    req_ch.task_id        = '0;
    req_ch.period         = '0;
    req_ch.handle_present = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(220, 1'b1, 1'b1);
    test_output_stall();
    test_random_mix(80, 1'b0, 1'b0);
    test_random_mix(80, 1'b1, 1'b1);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    tail = 0;
    while (sched_resp_q.size() != 0 && tail < WATCHDOG_LIMIT) begin
      @(posedge clk);
      tail++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d creates (%0d refused), %0d ticks, %0d dispatches (%0d found a slot)",
             n_create, n_refused, n_tick, n_dispatch, n_picked);
    $display("with random idling on both channels and one long response stall");
    if (errors == 0 && sched_resp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
